// ----- src/rxf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxf_pkg
// Shared constants and types of the receive address and duplicate filter.
// ----------------------------------------------------------------------------
package rxf_pkg;

    localparam int GROUP_ENTRIES = 32;
    localparam int PAYLOAD_BYTES = 64;

    localparam int GRP_AW = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
    localparam int PAY_AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [7:0] PAY_LEN = 8'(PAYLOAD_BYTES);

    localparam int HDR_W = 38;
    localparam logic [15:0] BROADCAST_ADDR = 16'h0000;

    // item opcodes
    localparam logic [2:0] OP_HEADER = 3'd0;
    localparam logic [2:0] OP_BYTE   = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // result codes
    localparam logic [2:0] V_DELIVER    = 3'd0;
    localparam logic [2:0] V_FILTERED   = 3'd1;
    localparam logic [2:0] V_DUPLICATE  = 3'd2;
    localparam logic [2:0] V_TABLE_OK   = 3'd3;
    localparam logic [2:0] V_TABLE_FULL = 3'd4;
    localparam logic [2:0] V_NOT_FOUND  = 3'd5;

    // register index, taken from paddr[2]
    localparam logic REG_OWN_ADDR = 1'b0;
    localparam logic REG_PROMISC  = 1'b1;

    typedef struct packed {
        logic add;
        logic remove;
        logic clear;
    } grp_cmd_t;

    typedef struct packed {
        logic hit;
        logic free_found;
    } grp_stat_t;

endpackage

// ----- src/rxf_group_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxf_group_table
// Group address table: parallel lookup, lowest-free-slot add, remove, clear.
// ----------------------------------------------------------------------------
module rxf_group_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        lookup_addr,
    input  rxf_pkg::grp_cmd_t  cmd,
    output rxf_pkg::grp_stat_t stat
);
    import rxf_pkg::*;

    logic [15:0]              entry_mem [GROUP_ENTRIES];
    logic [GROUP_ENTRIES-1:0] valid_reg;
    logic [GROUP_ENTRIES-1:0] valid_next;
    logic [GRP_AW-1:0]        hit_idx;
    logic [GRP_AW-1:0]        free_idx;
    logic                     hit;
    logic                     free_found;
    logic                     do_insert;

    // descending scan leaves the lowest index
    always_comb
    begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = GROUP_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && entry_mem[i] == lookup_addr)
            begin
                hit     = 1'b1;
                hit_idx = GRP_AW'(i);
            end
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = GRP_AW'(i);
            end
        end
    end

    assign do_insert = cmd.add && !hit && free_found;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = '0;
        end
        else if (do_insert)
        begin
            valid_next[free_idx] = 1'b1;
        end
        else if (cmd.remove && hit)
        begin
            valid_next[hit_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            entry_mem[free_idx] <= lookup_addr;
        end
    end

    assign stat.hit        = hit;
    assign stat.free_found = free_found;

endmodule

// ----- src/rx_frame_address_and_duplicate_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_frame_address_and_duplicate_filter_unit
// Address and duplicate filter for decoded link-layer frames.
// ----------------------------------------------------------------------------
// Each item is accepted in ST_IDLE; in the accept cycle the payload memory is
// read at the current byte position. The item is then carried out in ST_EXEC:
// the byte is compared, the frame state and group table are updated, the byte
// is written back and any verdict is loaded into the output register. in_stall
// is high in ST_EXEC, and ST_EXEC lasts for as long as an earlier verdict is held
// by out_stall. Frames are judged on their last item; table add, remove and
// clear items always answer. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module rx_frame_address_and_duplicate_filter_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [15:0] address,
    input  logic        dest_is_group,
    input  logic [15:0] source,
    input  logic        repeated,
    input  logic [1:0]  priority_req,
    input  logic [2:0]  hop_count,
    input  logic [7:0]  payload_byte,
    input  logic        last,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  verdict,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rxf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;

    // accepted item
    logic [2:0]  item_op_reg;
    logic [15:0] item_addr_reg;
    logic        item_dig_reg;
    logic [15:0] item_src_reg;
    logic        item_rep_reg;
    logic [1:0]  item_pri_reg;
    logic [2:0]  item_hop_reg;
    logic [7:0]  item_byte_reg;
    logic        item_last_reg;

    // frame state
    logic             lfv_reg, lfv_next;
    logic [HDR_W-1:0] last_header_reg, last_header_next;
    logic [7:0]       last_length_reg, last_length_next;
    logic [HDR_W:0]   cur_header_reg, cur_header_next;
    logic [7:0]       byte_index_reg, byte_index_next;
    logic             still_equal_reg, still_equal_next;
    logic             frame_open_reg, frame_open_next;
    logic             too_long_reg, too_long_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  verdict_reg, verdict_next;

    logic [15:0] own_address_reg;
    logic        promiscuous_reg;

    // payload store of the last kept frame
    logic [7:0]        pay_mem [PAYLOAD_BYTES];
    logic [7:0]        pay_rdata_reg;
    logic              pay_we;
    logic [PAY_AW-1:0] pay_addr;

    logic        can_go;
    logic        cfg_write;
    logic [15:0] lookup_addr;
    grp_cmd_t    grp_cmd;
    grp_stat_t   grp_stat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign can_go    = !out_valid_reg || !out_stall;
    assign pay_addr  = byte_index_reg[PAY_AW-1:0];

    // byte items look up the open frame's destination
    assign lookup_addr = (item_op_reg == OP_BYTE) ? cur_header_reg[21:6] : item_addr_reg;

    always_comb
    begin
        case (paddr[2])
            REG_OWN_ADDR: prdata = {16'd0, own_address_reg};
            REG_PROMISC:  prdata = {31'd0, promiscuous_reg};
            default:      prdata = '0;
        endcase
    end

    rxf_group_table u_group_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_addr (lookup_addr),
        .cmd         (grp_cmd),
        .stat        (grp_stat)
    );

    always_comb
    begin
        logic [HDR_W-1:0] hdr;
        logic [15:0]      dst;
        logic             rep;
        logic             is_grp;
        logic             to_own;
        logic             dup;
        logic             match;
        logic             do_judge;

        hdr      = '0;
        dst      = '0;
        rep      = 1'b0;
        is_grp   = 1'b0;
        to_own   = 1'b0;
        dup      = 1'b0;
        match    = 1'b0;
        do_judge = 1'b0;

        state_next       = state_reg;
        lfv_next         = lfv_reg;
        last_header_next = last_header_reg;
        last_length_next = last_length_reg;
        cur_header_next  = cur_header_reg;
        byte_index_next  = byte_index_reg;
        still_equal_next = still_equal_reg;
        frame_open_next  = frame_open_reg;
        too_long_next    = too_long_reg;
        out_valid_next   = out_valid_reg && out_stall;
        verdict_next     = verdict_reg;
        pay_we           = 1'b0;
        grp_cmd          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (can_go)
                begin
                    state_next = ST_IDLE;
                    case (item_op_reg)
                        OP_HEADER:
                        begin
                            cur_header_next = {item_rep_reg, item_src_reg, item_addr_reg,
                                               item_dig_reg, item_pri_reg, item_hop_reg};
                            byte_index_next  = '0;
                            too_long_next    = 1'b0;
                            still_equal_next = lfv_reg;
                            frame_open_next  = 1'b1;
                            do_judge         = item_last_reg;
                        end
                        OP_BYTE:
                        begin
                            if (frame_open_reg)
                            begin
                                if (too_long_reg || byte_index_reg >= PAY_LEN)
                                begin
                                    too_long_next    = 1'b1;
                                    still_equal_next = 1'b0;
                                end
                                else
                                begin
                                    if (byte_index_reg >= last_length_reg)
                                    begin
                                        still_equal_next = 1'b0;
                                    end
                                    else if (pay_rdata_reg != item_byte_reg)
                                    begin
                                        // stored copy is being overwritten
                                        still_equal_next = 1'b0;
                                        lfv_next         = 1'b0;
                                    end
                                    pay_we          = 1'b1;
                                    byte_index_next = byte_index_reg + 8'd1;
                                end
                                do_judge = item_last_reg;
                            end
                        end
                        OP_ADD:
                        begin
                            grp_cmd.add    = 1'b1;
                            out_valid_next = 1'b1;
                            verdict_next   = (grp_stat.hit || grp_stat.free_found) ?
                                             V_TABLE_OK : V_TABLE_FULL;
                        end
                        OP_REMOVE:
                        begin
                            grp_cmd.remove = 1'b1;
                            out_valid_next = 1'b1;
                            verdict_next   = grp_stat.hit ? V_TABLE_OK : V_NOT_FOUND;
                        end
                        OP_CLEAR:
                        begin
                            grp_cmd.clear  = 1'b1;
                            out_valid_next = 1'b1;
                            verdict_next   = V_TABLE_OK;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_judge)
                    begin
                        hdr    = cur_header_next[HDR_W-1:0];
                        rep    = cur_header_next[HDR_W];
                        dst    = hdr[21:6];
                        is_grp = hdr[5];
                        to_own = !is_grp && dst != BROADCAST_ADDR && dst == own_address_reg;
                        dup    = rep && lfv_next && still_equal_next && !too_long_next &&
                                 byte_index_next == last_length_reg && hdr == last_header_reg;
                        frame_open_next = 1'b0;
                        out_valid_next  = 1'b1;
                        if (!to_own && dup)
                        begin
                            verdict_next = V_DUPLICATE;
                        end
                        else
                        begin
                            lfv_next         = !too_long_next;
                            last_header_next = hdr;
                            last_length_next = byte_index_next;
                            match = promiscuous_reg || dst == BROADCAST_ADDR ||
                                    (is_grp ? grp_stat.hit : dst == own_address_reg);
                            verdict_next = match ? V_DELIVER : V_FILTERED;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            lfv_reg         <= 1'b0;
            last_header_reg <= '0;
            last_length_reg <= '0;
            cur_header_reg  <= '0;
            byte_index_reg  <= '0;
            still_equal_reg <= 1'b0;
            frame_open_reg  <= 1'b0;
            too_long_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            verdict_reg     <= V_DELIVER;
            own_address_reg <= '0;
            promiscuous_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lfv_reg         <= lfv_next;
            last_header_reg <= last_header_next;
            last_length_reg <= last_length_next;
            cur_header_reg  <= cur_header_next;
            byte_index_reg  <= byte_index_next;
            still_equal_reg <= still_equal_next;
            frame_open_reg  <= frame_open_next;
            too_long_reg    <= too_long_next;
            out_valid_reg   <= out_valid_next;
            verdict_reg     <= verdict_next;
            if (cfg_write)
            begin
                case (paddr[2])
                    REG_OWN_ADDR: own_address_reg <= pwdata[15:0];
                    REG_PROMISC:  promiscuous_reg <= pwdata[0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_op_reg   <= opcode;
            item_addr_reg <= address;
            item_dig_reg  <= dest_is_group;
            item_src_reg  <= source;
            item_rep_reg  <= repeated;
            item_pri_reg  <= priority_req;
            item_hop_reg  <= hop_count;
            item_byte_reg <= payload_byte;
            item_last_reg <= last;
        end
    end

    // read every cycle at the current position; the address moves on a write and a header item resets it to zero
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_addr] <= item_byte_reg;
        end
        pay_rdata_reg <= pay_mem[pay_addr];
    end

endmodule

// ----- src/rxf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxf_checker
// Port-level checks of the receive filter, bound to the top level.
// ----------------------------------------------------------------------------
module rxf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  opcode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  verdict
);
    import rxf_pkg::*;

    // an accepted item occupies the block for the following cycle
    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("in_stall low right after an accepted item");

    // a table item accepted with a free output register answers: ST_EXEC runs, then its verdict is registered
    property p_table_answers;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid &&
         (opcode == OP_ADD || opcode == OP_REMOVE || opcode == OP_CLEAR))
        |=> ##1 out_valid;
    endproperty
    a_table_answers: assert property (p_table_answers)
        else $error("table item gave no verdict");

    property p_verdict_code;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict <= V_NOT_FOUND);
    endproperty
    a_verdict_code: assert property (p_verdict_code)
        else $error("verdict code out of range");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(verdict));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled verdict changed or dropped");

endmodule

bind rx_frame_address_and_duplicate_filter_unit rxf_checker u_rxf_checker (.*);
